// File: src/kpmet_pkg.sv
// ---------------------------------------------------------------------------
// kpmet_pkg: shared types and constants of the pair tally table
// Field widths, action codes, table entry record and compare result.
// ---------------------------------------------------------------------------
package kpmet_pkg;

    localparam int RES_W = 14;   // residue index
    localparam int NUM_W = 15;   // one-based residue number
    localparam int EN_W  = 11;   // energy, tenths of kcal/mol, signed
    localparam int CNT_W = 8;    // file count
    localparam int ACT_W = 2;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic signed [EN_W-1:0] THR_RESET = -11'sd20;   // -2.0 kcal/mol
    localparam logic [CNT_W-1:0]       FILES_MAX = 8'd255;

    localparam logic [ACT_W-1:0] ACT_ADD     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_NEWFILE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REPORT  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd3;

    typedef struct packed {
        logic        [RES_W-1:0] donor;
        logic        [RES_W-1:0] acceptor;
        logic signed [EN_W-1:0]  energy;
        logic        [CNT_W-1:0] files;
    } pair_rec_t;

    typedef struct packed {
        pair_rec_t rec;
        logic      seen;
    } entry_t;

    typedef struct packed {
        logic                    hit;       // key matches
        logic                    qualify;   // passes report filter
        logic signed [EN_W-1:0]  energy;    // energy after a hit
        logic        [CNT_W-1:0] files;     // file count after a hit
    } cmp_res_t;

endpackage

// File: src/kpmet_table.sv
// ---------------------------------------------------------------------------
// kpmet_table: pair table storage
// One write port, one read port with registered read data. Seen bits sit in
// their own array so a new-file sweep can clear them without a read.
// ---------------------------------------------------------------------------
module kpmet_table
    import kpmet_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH)
)
(
    input  logic          clk,
    input  logic          we_entry,   // write whole entry incl. seen bit
    input  logic          we_seen,    // write seen bit only
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_entry,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_entry
);

    pair_rec_t rec_mem  [TABLE_DEPTH];
    logic      seen_mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we_entry)
        begin
            rec_mem[wr_addr] <= wr_entry.rec;
        end
        if (we_entry || we_seen)
        begin
            seen_mem[wr_addr] <= wr_entry.seen;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry.rec  <= rec_mem[rd_addr];
            rd_entry.seen <= seen_mem[rd_addr];
        end
    end

endmodule

// File: src/kpmet_cmp.sv
// ---------------------------------------------------------------------------
// kpmet_cmp: shared compare unit
// Key match and min/count update for adds, filter test for reports.
// ---------------------------------------------------------------------------
module kpmet_cmp
    import kpmet_pkg::*;
(
    input  entry_t                  entry,
    input  logic        [RES_W-1:0] key_donor,
    input  logic        [RES_W-1:0] key_acceptor,
    input  logic signed [EN_W-1:0]  energy,
    input  logic        [CNT_W-1:0] need,
    input  logic signed [EN_W-1:0]  threshold,
    output cmp_res_t                res
);

    always_comb
    begin
        res.hit     = (entry.rec.donor == key_donor) && (entry.rec.acceptor == key_acceptor);
        res.qualify = (entry.rec.files >= need) &&
                      ($signed(entry.rec.energy) < $signed(threshold));
        res.energy  = ($signed(energy) < $signed(entry.rec.energy)) ? energy
                                                                     : entry.rec.energy;
        // count once per file, saturating
        if (entry.seen || (entry.rec.files == FILES_MAX))
        begin
            res.files = entry.rec.files;
        end
        else
        begin
            res.files = entry.rec.files + 1'b1;
        end
    end

endmodule

// File: src/keyed_pair_min_energy_tally_table_core.sv
// ---------------------------------------------------------------------------
// keyed_pair_min_energy_tally_table_core: donor/acceptor pair tally table
// Sequenced table of residue pairs with minimum energy and file counts.
// ---------------------------------------------------------------------------
// One item is worked at a time; in_stall is high after the transfer until
// the item is finished (a clear never raises it). The table sits in a
// memory with one write port and one registered read port, so the cost
// per item follows the number of stored entries N (used_reg), scanned
// one per cycle unless out_stall holds back a report result:
//   add      : scan until a key hit (the scan stops there) or the end,
//              then append the new pair unless the table is full
//   report   : scan the whole table, waiting while out_stall holds a result
//   new file : a sweep that clears each entry's seen bit
//   clear    : reset the fill count without leaving idle
// A report yields its results in table order, the last one flagged by
// 'last'; with no match it yields a single none_found result. Residue
// numbers come out one-based. An add to a full table is dropped and sets
// the sticky table_overflow flag, which only reset clears. The energy
// threshold (reset -2.0 kcal/mol) is written through cfg_wr_en/cfg_wr_data
// and must only change while the block is idle. No clearing pass is needed
// after reset: entries past the fill count are never read.
// ---------------------------------------------------------------------------
module keyed_pair_min_energy_tally_table_core
    import kpmet_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_wr_en,
    input  logic signed [EN_W-1:0]  cfg_wr_data,
    // input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic        [ACT_W-1:0] action,
    input  logic        [RES_W-1:0] donor_residue,
    input  logic        [RES_W-1:0] acceptor_residue,
    input  logic signed [EN_W-1:0]  bond_energy,
    input  logic        [CNT_W-1:0] required_files,
    // result channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic        [NUM_W-1:0] donor_number,
    output logic        [NUM_W-1:0] acceptor_number,
    output logic signed [EN_W-1:0]  best_energy,
    output logic        [CNT_W-1:0] file_count,
    output logic                    none_found,
    output logic                    table_overflow,
    output logic                    last
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,    // add / report walk over the table
        ST_SWEEP    // new file: clear seen bits
    } state_t;

    // control
    state_t                  state_reg,    state_next;
    logic       [CW-1:0]     used_reg,     used_next;
    logic                    ovf_reg,      ovf_next;
    logic       [CW-1:0]     idx_reg,      idx_next;      // scan issue / sweep index
    logic                    dvld_reg,     dvld_next;     // read data in flight
    logic       [AW-1:0]     didx_reg,     didx_next;     // index of read data
    logic                    hold_vld_reg, hold_vld_next; // a match waits for its successor
    logic                    out_vld_reg,  out_vld_next;
    logic signed [EN_W-1:0]  thr_reg,      thr_next;

    // payload
    logic       [ACT_W-1:0]  act_reg,      act_next;
    logic       [RES_W-1:0]  key_d_reg,    key_d_next;
    logic       [RES_W-1:0]  key_a_reg,    key_a_next;
    logic signed [EN_W-1:0]  en_reg,       en_next;
    logic       [CNT_W-1:0]  need_reg,     need_next;
    entry_t                  hold_reg,     hold_next;
    logic       [NUM_W-1:0]  od_reg,       od_next;
    logic       [NUM_W-1:0]  oa_reg,       oa_next;
    logic signed [EN_W-1:0]  oe_reg,       oe_next;
    logic       [CNT_W-1:0]  of_reg,       of_next;
    logic                    onone_reg,    onone_next;
    logic                    oovf_reg,     oovf_next;
    logic                    olast_reg,    olast_next;

    // table and compare unit
    logic          we_entry;
    logic          we_seen;
    logic [AW-1:0] wr_addr;
    entry_t        wr_entry;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_entry;
    cmp_res_t      cmp;

    logic out_free;
    logic scan_done;

    kpmet_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk      (clk),
        .we_entry (we_entry),
        .we_seen  (we_seen),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    kpmet_cmp u_cmp (
        .entry        (rd_entry),
        .key_donor    (key_d_reg),
        .key_acceptor (key_a_reg),
        .energy       (en_reg),
        .need         (need_reg),
        .threshold    (thr_reg),
        .res          (cmp)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_vld_reg || !out_stall;
    // every entry issued and the last read data consumed
    assign scan_done = !dvld_reg && (idx_reg >= used_reg);

    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        ovf_next      = ovf_reg;
        idx_next      = idx_reg;
        dvld_next     = dvld_reg;
        didx_next     = didx_reg;
        hold_vld_next = hold_vld_reg;
        thr_next      = thr_reg;
        act_next      = act_reg;
        key_d_next    = key_d_reg;
        key_a_next    = key_a_reg;
        en_next       = en_reg;
        need_next     = need_reg;
        hold_next     = hold_reg;
        od_next       = od_reg;
        oa_next       = oa_reg;
        oe_next       = oe_reg;
        of_next       = of_reg;
        onone_next    = onone_reg;
        oovf_next     = oovf_reg;
        olast_next    = olast_reg;

        out_vld_next  = out_vld_reg && out_stall;

        we_entry      = 1'b0;
        we_seen       = 1'b0;
        wr_addr       = didx_reg;
        wr_entry.rec  = '{donor: key_d_reg, acceptor: key_a_reg,
                          energy: cmp.energy, files: cmp.files};
        wr_entry.seen = 1'b1;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[AW-1:0];

        if (cfg_wr_en)
        begin
            thr_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next      = action;
                    key_d_next    = donor_residue;
                    key_a_next    = acceptor_residue;
                    en_next       = bond_energy;
                    need_next     = required_files;
                    idx_next      = '0;
                    dvld_next     = 1'b0;
                    hold_vld_next = 1'b0;
                    case (action)
                        ACT_ADD,
                        ACT_REPORT:  state_next = ST_SCAN;
                        ACT_NEWFILE: state_next = ST_SWEEP;
                        ACT_CLEAR:   used_next  = '0;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (dvld_reg && (act_reg == ACT_ADD) && cmp.hit)
                begin
                    // hit: lower energy, count file once, done
                    we_entry   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (dvld_reg && (act_reg == ACT_REPORT) && cmp.qualify &&
                         hold_vld_reg && !out_free)
                begin
                    // result register busy: freeze the walk
                end
                else if (scan_done)
                begin
                    if (act_reg == ACT_ADD)
                    begin
                        if (used_reg != DEPTH_C)
                        begin
                            we_entry      = 1'b1;
                            wr_addr       = used_reg[AW-1:0];
                            wr_entry.rec  = '{donor: key_d_reg, acceptor: key_a_reg,
                                              energy: en_reg, files: CNT_W'(1)};
                            used_next     = used_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        // closing transfer of the report
                        out_vld_next  = 1'b1;
                        od_next       = hold_vld_reg ? NUM_W'(hold_reg.rec.donor) + 1'b1 : '0;
                        oa_next       = hold_vld_reg ? NUM_W'(hold_reg.rec.acceptor) + 1'b1
                                                     : '0;
                        oe_next       = hold_vld_reg ? hold_reg.rec.energy : '0;
                        of_next       = hold_vld_reg ? hold_reg.rec.files : '0;
                        onone_next    = !hold_vld_reg;
                        oovf_next     = ovf_reg;
                        olast_next    = 1'b1;
                        hold_vld_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    if (dvld_reg && (act_reg == ACT_REPORT) && cmp.qualify)
                    begin
                        if (hold_vld_reg)
                        begin
                            out_vld_next = 1'b1;
                            od_next      = NUM_W'(hold_reg.rec.donor) + 1'b1;
                            oa_next      = NUM_W'(hold_reg.rec.acceptor) + 1'b1;
                            oe_next      = hold_reg.rec.energy;
                            of_next      = hold_reg.rec.files;
                            onone_next   = 1'b0;
                            oovf_next    = ovf_reg;
                            olast_next   = 1'b0;
                        end
                        hold_next     = rd_entry;
                        hold_vld_next = 1'b1;
                    end
                    if (idx_reg < used_reg)
                    begin
                        rd_en     = 1'b1;
                        dvld_next = 1'b1;
                        didx_next = idx_reg[AW-1:0];
                        idx_next  = idx_reg + 1'b1;
                    end
                    else
                    begin
                        dvld_next = 1'b0;
                    end
                end
            end

            ST_SWEEP:
            begin
                if (idx_reg < used_reg)
                begin
                    we_seen       = 1'b1;
                    wr_addr       = idx_reg[AW-1:0];
                    wr_entry.seen = 1'b0;
                    idx_next      = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            ovf_reg      <= 1'b0;
            idx_reg      <= '0;
            dvld_reg     <= 1'b0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            thr_reg      <= THR_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            ovf_reg      <= ovf_next;
            idx_reg      <= idx_next;
            dvld_reg     <= dvld_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
            thr_reg      <= thr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        didx_reg  <= didx_next;
        act_reg   <= act_next;
        key_d_reg <= key_d_next;
        key_a_reg <= key_a_next;
        en_reg    <= en_next;
        need_reg  <= need_next;
        hold_reg  <= hold_next;
        od_reg    <= od_next;
        oa_reg    <= oa_next;
        oe_reg    <= oe_next;
        of_reg    <= of_next;
        onone_reg <= onone_next;
        oovf_reg  <= oovf_next;
        olast_reg <= olast_next;
    end

    assign out_valid       = out_vld_reg;
    assign donor_number    = od_reg;
    assign acceptor_number = oa_reg;
    assign best_energy     = oe_reg;
    assign file_count      = of_reg;
    assign none_found      = onone_reg;
    assign table_overflow  = oovf_reg;
    assign last            = olast_reg;

    // fill count never passes the table size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= DEPTH_C)
        else $error("fill count beyond table depth");

    // overflow flag is sticky until reset
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag dropped");

    // a held match only exists during a table walk
    a_hold_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        hold_vld_reg |-> (state_reg == ST_SCAN))
        else $error("held match outside scan");

    // a none-found result is always the final one of its report
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && onone_reg) |-> olast_reg)
        else $error("none_found without last");

endmodule
